>>> rtl/mhq_pkg.sv
// Shared constants and types for the monotone hull line store.
`default_nettype none

package mhq_pkg;

	// Store geometry
	localparam int LINE_DEPTH = 1024;
	localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int IDX_W      = $clog2(LINE_DEPTH + 1);

	// Field widths
	localparam int CMD_W   = 2;
	localparam int SLOPE_W = 32;
	localparam int ICPT_W  = 64;
	localparam int TAG_W   = 20;
	localparam int X_W     = 32;

	// Multiplier bank
	localparam int MUL_W     = 32;
	localparam int MUL_LANES = 4;
	localparam int PROD_W    = 2 * MUL_W;

	// Pop test products: 64-bit magnitude times 32-bit magnitude
	localparam int MAG_W = ICPT_W + SLOPE_W;
	// Exact line value: unsigned 64-bit product plus signed 64-bit intercept
	localparam int VAL_W = ICPT_W + 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [SLOPE_W-1:0]       slope;
		logic signed [ICPT_W-1:0] intercept;
		logic [TAG_W-1:0]         tag;
	} line_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr_a;
		logic [ADDR_W-1:0] rd_addr_b;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		line_t             wr_data;
	} ram_req_t;

	typedef logic [MUL_LANES-1:0][MUL_W-1:0]  mul_opnd_t;
	typedef logic [MUL_LANES-1:0][PROD_W-1:0] mul_prod_t;

endpackage

`default_nettype wire

>>> rtl/mhq_line_ram.sv
// Line store: one write port, two read ports, registered read data.
`default_nettype none

module mhq_line_ram (
	input  logic              clk,
	input  mhq_pkg::ram_req_t req,
	output mhq_pkg::line_t    rd_data_a,
	output mhq_pkg::line_t    rd_data_b
);
	import mhq_pkg::*;

	line_t mem [LINE_DEPTH];

	// Read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_a <= mem[req.rd_addr_a];
			rd_data_b <= mem[req.rd_addr_b];
		end
	end

endmodule

`default_nettype wire

>>> rtl/mhq_mul4.sv
// Four lanes of registered 32x32 unsigned multipliers.
`default_nettype none

module mhq_mul4 (
	input  logic               clk,
	input  mhq_pkg::mul_opnd_t opnd_a,
	input  mhq_pkg::mul_opnd_t opnd_b,
	output mhq_pkg::mul_prod_t prod
);
	import mhq_pkg::*;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MUL_LANES; i++) begin
			prod[i] <= PROD_W'(opnd_a[i]) * PROD_W'(opnd_b[i]);
		end
	end

endmodule

`default_nettype wire

>>> rtl/monotone_hull_line_max_query.sv
// Top level of the monotone hull line store: sequencer, datapath and instances.
//
// Keeps a deque of lines (slope, intercept, tag) in a 1024-entry line memory and answers
// maximum queries. A request carries cmd (insert, query or clear); only a query returns a
// result (best_value saturated to the signed 64-bit range, best_tag, empty_res). One
// request is in work at a time; req_stall is high from acceptance until the sequencer is
// back in idle. Every pop test and every head step is a read of two entries from the line
// memory (registered read data) followed by the shared four-lane 32x32 multiplier bank, a
// sum stage and a compare stage; a pop test also has a difference stage before the
// multiplier bank. Clear and unused commands never leave idle. A query result waits in
// the done state until the output register is free. The result sits in an output
// register, so the next request is accepted while a result is still held by res_stall.
// The memory needs no clearing pass: only entries between head and tail, written since
// the last clear, are ever used.
`default_nettype none

module monotone_hull_line_max_query (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [mhq_pkg::CMD_W-1:0]          cmd,
	input  logic [mhq_pkg::SLOPE_W-1:0]        slope,
	input  logic signed [mhq_pkg::ICPT_W-1:0]  intercept,
	input  logic [mhq_pkg::TAG_W-1:0]          line_tag,
	input  logic [mhq_pkg::X_W-1:0]            query_x,
	// result channel
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic signed [mhq_pkg::ICPT_W-1:0]  best_value,
	output logic [mhq_pkg::TAG_W-1:0]          best_tag,
	output logic                               empty_res
);
	import mhq_pkg::*;

	// Sequencer states. RD issues the two reads, DIFF forms the pop test operands
	// (insert only), MUL runs the multiplier bank, SUM assembles products, CMP decides.
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_RD   = 8'b0000_0010,
		ST_DIFF = 8'b0000_0100,
		ST_MUL  = 8'b0000_1000,
		ST_SUM  = 8'b0001_0000,
		ST_CMP  = 8'b0010_0000,
		ST_WR   = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	localparam logic signed [ICPT_W-1:0] VAL_MAX = {1'b0, {(ICPT_W-1){1'b1}}};
	localparam logic signed [ICPT_W-1:0] VAL_MIN = {1'b1, {(ICPT_W-1){1'b0}}};

	// Control state
	state_t           state_q;
	logic             is_query_q;
	logic             empty_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [IDX_W-1:0] work_q;     // working tail during an insert
	logic             res_valid_q;

	// Request payload
	logic [SLOPE_W-1:0]       slope_q;
	logic signed [ICPT_W-1:0] icpt_q;
	logic [TAG_W-1:0]         tag_q;
	logic [X_W-1:0]           x_q;

	// Pop test operands: magnitudes and signs of the intercept and slope differences
	logic [ICPT_W-1:0]  m1_q, m2_q;
	logic [SLOPE_W-1:0] sm1_q, sm2_q;
	logic               neg1_q, neg2_q;
	logic [MAG_W-1:0]   lhs_q, rhs_q;

	// Exact line values at x for head and head + 1
	logic signed [VAL_W-1:0] v0_q, v1_q;

	// Output register
	logic signed [ICPT_W-1:0] best_value_q;
	logic [TAG_W-1:0]         best_tag_q;
	logic                     empty_res_q;

	ram_req_t  ram_req;
	line_t     rd_a, rd_b;
	mul_opnd_t mul_a, mul_b;
	mul_prod_t prod;

	logic             accept;
	logic             out_free;
	logic [IDX_W-1:0] idx_a, idx_b;
	logic             has_pair;
	logic             store_room;
	logic             more_lines;

	// DIFF stage
	logic               ge1, ge2, sn1, sn2;
	logic [ICPT_W-1:0]  d1_mag, d2_mag;
	logic [SLOPE_W-1:0] e1_mag, e2_mag;

	// CMP stage
	logic lneg, rneg, useless, value_le;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !res_valid_q || !res_stall;

	// Query reads head and head + 1; insert reads the last two kept lines
	assign idx_a = is_query_q ? head_q : work_q - IDX_W'(2);
	assign idx_b = is_query_q ? head_q + IDX_W'(1) : work_q - IDX_W'(1);

	assign has_pair   = (work_q - head_q) >= IDX_W'(2);
	assign store_room = work_q < IDX_W'(LINE_DEPTH);
	assign more_lines = (head_q + IDX_W'(1)) < tail_q;

	always_comb begin
		ram_req           = '0;
		ram_req.rd_en     = (state_q == ST_RD);
		ram_req.rd_addr_a = idx_a[ADDR_W-1:0];
		ram_req.rd_addr_b = idx_b[ADDR_W-1:0];
		ram_req.wr_en     = (state_q == ST_WR) && store_room;
		ram_req.wr_addr   = work_q[ADDR_W-1:0];
		ram_req.wr_data.slope     = slope_q;
		ram_req.wr_data.intercept = icpt_q;
		ram_req.wr_data.tag       = tag_q;
	end

	mhq_line_ram u_ram (
		.clk       (clk),
		.req       (ram_req),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	// a = rd_a, b = rd_b, c = new line
	// d1 = a.c - c.c, d2 = a.c - b.c, e1 = b.s - a.s, e2 = c.s - a.s
	always_comb begin
		ge1    = rd_a.intercept >= icpt_q;
		ge2    = rd_a.intercept >= rd_b.intercept;
		d1_mag = ge1 ? ICPT_W'(rd_a.intercept - icpt_q) : ICPT_W'(icpt_q - rd_a.intercept);
		d2_mag = ge2 ? ICPT_W'(rd_a.intercept - rd_b.intercept)
		             : ICPT_W'(rd_b.intercept - rd_a.intercept);
		sn1    = rd_b.slope < rd_a.slope;
		sn2    = slope_q < rd_a.slope;
		e1_mag = sn1 ? rd_a.slope - rd_b.slope : rd_b.slope - rd_a.slope;
		e2_mag = sn2 ? rd_a.slope - slope_q : slope_q - rd_a.slope;
	end

	// Lanes 0/1: lhs halves (insert) or slope*x for both lines (query). Lanes 2/3: rhs.
	always_comb begin
		mul_a[0] = is_query_q ? rd_a.slope : m1_q[MUL_W-1:0];
		mul_b[0] = is_query_q ? x_q : sm1_q;
		mul_a[1] = is_query_q ? rd_b.slope : m1_q[ICPT_W-1:MUL_W];
		mul_b[1] = is_query_q ? x_q : sm1_q;
		mul_a[2] = m2_q[MUL_W-1:0];
		mul_b[2] = sm2_q;
		mul_a[3] = m2_q[ICPT_W-1:MUL_W];
		mul_b[3] = sm2_q;
	end

	mhq_mul4 u_mul (
		.clk    (clk),
		.opnd_a (mul_a),
		.opnd_b (mul_b),
		.prod   (prod)
	);

	// Signed-magnitude lhs <= rhs; a zero product counts as non-negative
	always_comb begin
		lneg = neg1_q && (lhs_q != '0);
		rneg = neg2_q && (rhs_q != '0);
		if (lneg != rneg) begin
			useless = lneg;
		end else if (lneg) begin
			useless = lhs_q >= rhs_q;
		end else begin
			useless = lhs_q <= rhs_q;
		end
		value_le = v0_q <= v1_q;
	end

	// Sequencer and deque indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			is_query_q  <= 1'b0;
			empty_q     <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			work_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// a new result wins over the departure of the old one
			if ((state_q == ST_DONE) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_INSERT: begin
								is_query_q <= 1'b0;
								work_q     <= tail_q;
								state_q    <= ST_RD;
							end
							CMD_QUERY: begin
								is_query_q <= 1'b1;
								empty_q    <= (head_q >= tail_q);
								state_q    <= (head_q >= tail_q) ? ST_DONE : ST_RD;
							end
							CMD_CLEAR: begin
								head_q <= '0;
								tail_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RD: begin
					if (is_query_q) begin
						state_q <= ST_MUL;
					end else if (has_pair) begin
						state_q <= ST_DIFF;
					end else begin
						state_q <= ST_WR;
					end
				end
				ST_DIFF: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_CMP;
				ST_CMP: begin
					if (is_query_q) begin
						if (more_lines && value_le) begin
							head_q  <= head_q + IDX_W'(1);
							state_q <= ST_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (useless) begin
						work_q  <= work_q - IDX_W'(1);
						state_q <= ST_RD;
					end else begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					// a full store drops the whole insert: tail stays as it was
					if (store_room) begin
						tail_q <= work_q + IDX_W'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			slope_q <= slope;
			icpt_q  <= intercept;
			tag_q   <= line_tag;
			x_q     <= query_x;
		end
		if (state_q == ST_DIFF) begin
			m1_q   <= d1_mag;
			m2_q   <= d2_mag;
			sm1_q  <= e1_mag;
			sm2_q  <= e2_mag;
			neg1_q <= !ge1 ^ sn1;
			neg2_q <= !ge2 ^ sn2;
		end
		if (state_q == ST_SUM) begin
			lhs_q <= MAG_W'(prod[0]) + {prod[1], {MUL_W{1'b0}}};
			rhs_q <= MAG_W'(prod[2]) + {prod[3], {MUL_W{1'b0}}};
			v0_q  <= {2'b00, prod[0]} + {{2{rd_a.intercept[ICPT_W-1]}}, rd_a.intercept};
			v1_q  <= {2'b00, prod[1]} + {{2{rd_b.intercept[ICPT_W-1]}}, rd_b.intercept};
		end
		if ((state_q == ST_DONE) && out_free) begin
			if (empty_q) begin
				best_value_q <= '0;
				best_tag_q   <= '0;
				empty_res_q  <= 1'b1;
			end else begin
				// saturate the exact value to the signed 64-bit range
				if ((v0_q[VAL_W-1] == v0_q[VAL_W-2]) && (v0_q[VAL_W-2] == v0_q[ICPT_W-1])) begin
					best_value_q <= v0_q[ICPT_W-1:0];
				end else if (v0_q[VAL_W-1]) begin
					best_value_q <= VAL_MIN;
				end else begin
					best_value_q <= VAL_MAX;
				end
				best_tag_q  <= rd_a.tag;
				empty_res_q <= 1'b0;
			end
		end
	end

	assign res_valid  = res_valid_q;
	assign best_value = best_value_q;
	assign best_tag   = best_tag_q;
	assign empty_res  = empty_res_q;

endmodule

`default_nettype wire

>>> rtl/mhq_port_checker.sv
// Port-level checks for the monotone hull line store, bound to the top level.
`default_nettype none

module mhq_port_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_stall,
	input logic [mhq_pkg::CMD_W-1:0]          cmd,
	input logic [mhq_pkg::SLOPE_W-1:0]        slope,
	input logic signed [mhq_pkg::ICPT_W-1:0]  intercept,
	input logic [mhq_pkg::TAG_W-1:0]          line_tag,
	input logic [mhq_pkg::X_W-1:0]            query_x,
	input logic                               res_valid,
	input logic                               res_stall,
	input logic signed [mhq_pkg::ICPT_W-1:0]  best_value,
	input logic [mhq_pkg::TAG_W-1:0]          best_tag,
	input logic                               empty_res
);
	import mhq_pkg::*;

	logic req_acc;
	assign req_acc = req_valid && !req_stall;

	// stalled result keeps valid and payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(best_value) && $stable(best_tag)
			&& $stable(empty_res))
		else $error("stalled result changed");

	// stalled request keeps valid and payload
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(cmd) && $stable(slope)
			&& $stable(intercept) && $stable(line_tag) && $stable(query_x))
		else $error("stalled request changed");

	// empty result carries zero value and tag
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && empty_res |-> (best_value == '0) && (best_tag == '0))
		else $error("empty result with nonzero payload");

	// clear and unused commands finish in the accepting cycle
	a_clear_fast: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (cmd != CMD_INSERT) && (cmd != CMD_QUERY) |=> !req_stall)
		else $error("clear or unused command kept the block busy");

	// insert and query always take further cycles
	a_work_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && ((cmd == CMD_INSERT) || (cmd == CMD_QUERY)) |=> req_stall)
		else $error("insert or query accepted without going busy");

endmodule

bind monotone_hull_line_max_query mhq_port_checker u_port_checker (.*);

`default_nettype wire
